// File: hw/rtl/stkl_pkg.sv
// Package for the sorted top-k list: entry type, cell control struct,
// operation and status codes, and the list capacity.
// Depends on nothing; every other file imports it.
package stkl_pkg;

    // Number of slots in the list and the width of the fill counter.
    localparam int CAPACITY = 8;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    // Operation codes carried on the slave-side tuser.
    typedef enum logic [0:0] {
        OP_ADD    = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    // Status codes carried on the master-side tuser.
    typedef enum logic [1:0] {
        STATUS_INSERTED  = 2'd0,
        STATUS_DROPPED   = 2'd1,
        STATUS_REMOVED   = 2'd2,
        STATUS_OUT_RANGE = 2'd3
    } status_t;

    // One list entry: signed score plus identifier tag.
    typedef struct packed {
        logic signed [31:0] score;
        logic        [15:0] id;
    } entry_t;

    // Per-cell control from the top level for the current word.
    typedef struct packed {
        logic   update;    // commit the operation this cycle
        logic   remove;    // remove rather than insert
        logic   shift_up;  // cell is at or below the removed slot
        logic   valid;     // cell holds a live entry
        entry_t new_entry; // entry offered by an add
    } cell_ctrl_t;

endpackage

// File: hw/rtl/stkl_cell.sv
// One slot of the sorted list: holds an entry and trades it with its
// neighbors on an insert (shift down) or a remove (shift up).
// Depends on stkl_pkg.
module stkl_cell
    import stkl_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     prev_entry,  // entry of the slot above
    input  logic       prev_take,   // slot above is giving up its place
    input  entry_t     next_entry,  // entry of the slot below
    output entry_t     entry,
    output logic       take         // this slot gives up its place on an add
);

    entry_t entry_reg;
    entry_t entry_next;

    // A slot yields on an add when it is empty or the new score beats it.
    assign take  = !ctrl.valid || (ctrl.new_entry.score > entry_reg.score);
    assign entry = entry_reg;

    // Next entry: pull from below on a remove, from above or the new
    // entry on an insert.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.update)
        begin
            if (ctrl.remove)
            begin
                if (ctrl.shift_up)
                begin
                    entry_next = next_entry;
                end
            end
            else if (take)
            begin
                entry_next = prev_take ? prev_entry : ctrl.new_entry;
            end
        end
    end

    // Slot storage holds payload only and needs no reset.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: hw/rtl/sorted_top_k_list_core.sv
// Sorted top-k list core: a row of CAPACITY slot cells kept in descending
// score order. The result word of an accepted input word is written to the
// output register in the next cycle. Throughput is one word per cycle while the
// output is not stalled; every cell compares and shifts with its neighbors in the same cycle.
// Reset (rst_n low, asynchronous) empties the list and clears the output
// valid; slot contents stay undefined until written.
module sorted_top_k_list_core
    import stkl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, lowest bit up: entry_score[31:0], entry_id[47:32],
    // position[50:48], zero fill[55:51]
    input  logic [55:0] s_tdata,
    // s_tuser: operation[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, lowest bit up: removed_score[31:0], removed_id[47:32],
    // fill_count[51:48], zero fill[55:52]
    output logic [55:0] m_tdata,
    // m_tuser: status[1:0]
    output logic [1:0]  m_tuser
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    logic [55:0]        m_tdata_reg;
    logic [55:0]        m_tdata_next;
    logic [1:0]         m_tuser_reg;
    logic [1:0]         m_tuser_next;

    logic               accept;
    logic               is_remove;
    entry_t             in_entry;
    logic [2:0]         position;
    logic               full;
    logic               out_range;
    logic               drop;
    logic               update;
    entry_t             hit_entry;
    status_t            status;
    entry_t             removed;

    entry_t             entries [CAPACITY];
    logic               takes   [CAPACITY];
    cell_ctrl_t         ctrls   [CAPACITY];
    entry_t             hit_terms [CAPACITY];

    // Input word fields and handshake.
    assign s_tready       = !m_tvalid_reg || m_tready;
    assign accept         = s_tvalid && s_tready;
    assign is_remove      = (s_tuser[0] == OP_REMOVE);
    assign in_entry.score = s_tdata[31:0];
    assign in_entry.id    = s_tdata[47:32];
    assign position       = s_tdata[50:48];

    // Decide whether the word changes the list.
    assign full      = (32'(count_reg) >= 32'(CAPACITY));
    assign out_range = (32'(position) >= 32'(count_reg));
    assign drop      = full && !takes[CAPACITY-1];
    assign update    = accept && (is_remove ? !out_range : !drop);

    // Row of slot cells with neighbor links.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t prev_e;
        logic   prev_t;
        entry_t next_e;

        assign ctrls[i].update    = update;
        assign ctrls[i].remove    = is_remove;
        assign ctrls[i].shift_up  = (32'(i) >= 32'(position));
        assign ctrls[i].valid     = (32'(i) < 32'(count_reg));
        assign ctrls[i].new_entry = in_entry;

        if (i == 0)
        begin : g_first
            assign prev_e = '0;
            assign prev_t = 1'b0;
        end
        else
        begin : g_inner
            assign prev_e = entries[i-1];
            assign prev_t = takes[i-1];
        end

        // The last slot keeps its own entry when the row shifts up.
        if (i == CAPACITY - 1)
        begin : g_last
            assign next_e = entries[i];
        end
        else
        begin : g_more
            assign next_e = entries[i+1];
        end

        stkl_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrls[i]),
            .prev_entry (prev_e),
            .prev_take  (prev_t),
            .next_entry (next_e),
            .entry      (entries[i]),
            .take       (takes[i])
        );

        // Masked copy of the slot picked for removal.
        assign hit_terms[i] = (32'(i) == 32'(position)) ? entries[i] : '0;
    end

    // OR the masked slots together to read the removed entry.
    always_comb
    begin
        hit_entry = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_entry = hit_entry | hit_terms[i];
        end
    end

    // Status, removed entry and new fill count.
    always_comb
    begin
        count_next = count_reg;
        removed    = '0;
        if (is_remove)
        begin
            if (out_range)
            begin
                status = STATUS_OUT_RANGE;
            end
            else
            begin
                status  = STATUS_REMOVED;
                removed = hit_entry;
                if (accept)
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
        end
        else if (drop)
        begin
            status = STATUS_DROPPED;
        end
        else
        begin
            status = STATUS_INSERTED;
            if (accept && !full)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    // Output register next values.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (accept)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0, 4'(count_next), removed.id, removed.score};
            m_tuser_next  = status;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(CAPACITY))
        else $error("fill count above capacity");

    // A successful remove lowers the count by one.
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_remove && !out_range) |=> (count_reg == $past(count_reg) - COUNT_W'(1)))
        else $error("remove did not lower the fill count");

    // A rejected word leaves the count unchanged.
    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !update) |=> (count_reg == $past(count_reg)))
        else $error("rejected word changed the fill count");

    // The reported fill count matches the list after an accepted word.
    a_report_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (m_tdata_reg[51:48] == 4'(count_reg)))
        else $error("reported fill count differs from list");

endmodule
